// ----- rtl/wtv_pkg.sv -----
// Shared types, register codes and widths for the world-to-view transform.
package wtv_pkg;

   localparam int PT_W       = 32;
   localparam int DIFF_W     = PT_W + 1;
   localparam int COEF_W     = 17;
   localparam int PROD_W     = DIFF_W + COEF_W;
   localparam int ROW_W      = PROD_W + 2;
   localparam int VEC_W      = 48;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   localparam logic [2:0] REG_EYE_X  = 3'd0;
   localparam logic [2:0] REG_EYE_Y  = 3'd1;
   localparam logic [2:0] REG_EYE_Z  = 3'd2;
   localparam logic [2:0] REG_UP     = 3'd3;
   localparam logic [2:0] REG_NORMAL = 3'd4;

   localparam logic [VEC_W-1:0] UP_RESET     = 48'h0000_4000_0000;
   localparam logic [VEC_W-1:0] NORMAL_RESET = 48'h4000_0000_0000;

   typedef struct packed {
      logic signed [COEF_W-1:0] x;
      logic signed [COEF_W-1:0] y;
      logic signed [COEF_W-1:0] z;
   } coef_vec_type;

   typedef struct packed {
      coef_vec_type u;
      coef_vec_type v;
      coef_vec_type n;
      logic         degenerate;
      logic         busy;
   } basis_type;

   typedef enum logic [2:0] {
      ST_START,
      ST_SUM,
      ST_ROOT,
      ST_LOAD,
      ST_DIV,
      ST_CROSS,
      ST_IDLE
   } seq_state_type;

endpackage

// ----- rtl/world_to_view_transform_top.sv -----
// Top level: register port, basis sequencer and point pipeline.
//
//   channel   direction  handshake              word
//   req_      in         req_valid/req_ready    point_x, point_y, point_z
//   rsp_      out        rsp_valid/rsp_ready    view_x, view_y, view_z, degenerate
//   csr_      in/out     psel/penable, pready   eye_x/y/z, up_vector, view_normal
//
// One point per cycle while req_ready is high and rsp_ready does not stall; rsp_valid
// is driven by the last of the four stage registers.
// After reset and after each write of up_vector or view_normal the basis sequencer
// runs (up to two square roots, six divides, multiply-adds), and req_ready stays
// low until it finishes.
// A stall on rsp_ready backs up stage by stage; bubbles still fill.
module world_to_view_transform_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [wtv_pkg::PT_W-1:0]       req_point_x,
   input  logic signed [wtv_pkg::PT_W-1:0]       req_point_y,
   input  logic signed [wtv_pkg::PT_W-1:0]       req_point_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [wtv_pkg::PT_W-1:0]       rsp_view_x,
   output logic signed [wtv_pkg::PT_W-1:0]       rsp_view_y,
   output logic signed [wtv_pkg::PT_W-1:0]       rsp_view_z,
   output logic                                  rsp_degenerate,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [wtv_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [wtv_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [wtv_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready
);

   logic [wtv_pkg::PT_W-1:0]  eye_x_ff, eye_y_ff, eye_z_ff;
   logic [wtv_pkg::VEC_W-1:0] up_ff, normal_ff;
   logic [2:0] csr_idx;
   logic       csr_wr;
   logic       kick;
   wtv_pkg::basis_type basis;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[5:3];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign kick       = csr_wr && (csr_idx == wtv_pkg::REG_UP || csr_idx == wtv_pkg::REG_NORMAL);

   always_ff @(posedge clock) begin
      if (reset) begin
         eye_x_ff  <= '0;
         eye_y_ff  <= '0;
         eye_z_ff  <= '0;
         up_ff     <= wtv_pkg::UP_RESET;
         normal_ff <= wtv_pkg::NORMAL_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            wtv_pkg::REG_EYE_X:  eye_x_ff  <= csr_pwdata[31:0];
            wtv_pkg::REG_EYE_Y:  eye_y_ff  <= csr_pwdata[31:0];
            wtv_pkg::REG_EYE_Z:  eye_z_ff  <= csr_pwdata[31:0];
            wtv_pkg::REG_UP:     up_ff     <= csr_pwdata[47:0];
            wtv_pkg::REG_NORMAL: normal_ff <= csr_pwdata[47:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         wtv_pkg::REG_EYE_X:  csr_prdata = {32'b0, eye_x_ff};
         wtv_pkg::REG_EYE_Y:  csr_prdata = {32'b0, eye_y_ff};
         wtv_pkg::REG_EYE_Z:  csr_prdata = {32'b0, eye_z_ff};
         wtv_pkg::REG_UP:     csr_prdata = {16'b0, up_ff};
         wtv_pkg::REG_NORMAL: csr_prdata = {16'b0, normal_ff};
         default:             csr_prdata = '0;
      endcase
   end

   wtv_basis u_basis (
      .clock       (clock),
      .reset       (reset),
      .kick        (kick),
      .up_vector   (up_ff),
      .view_normal (normal_ff),
      .basis       (basis)
   );

   wtv_pipe u_pipe (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_point_z    (req_point_z),
      .eye_x          (eye_x_ff),
      .eye_y          (eye_y_ff),
      .eye_z          (eye_z_ff),
      .basis          (basis),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_view_x     (rsp_view_x),
      .rsp_view_y     (rsp_view_y),
      .rsp_view_z     (rsp_view_z),
      .rsp_degenerate (rsp_degenerate)
   );

endmodule

// ----- rtl/wtv_basis.sv -----
// Sequencer that builds the u, v, n rotation rows from the up and normal registers.
module wtv_basis (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         kick,
   input  logic [wtv_pkg::VEC_W-1:0]    up_vector,
   input  logic [wtv_pkg::VEC_W-1:0]    view_normal,
   output wtv_pkg::basis_type           basis
);

   function automatic logic [1:0] nx1(input logic [1:0] c);
      nx1 = (c == 2'd2) ? 2'd0 : c + 2'd1;
   endfunction

   function automatic logic [1:0] nx2(input logic [1:0] c);
      nx2 = (c == 2'd0) ? 2'd2 : c - 2'd1;
   endfunction

   logic signed [15:0] nr [3];
   logic signed [15:0] up [3];

   wtv_pkg::seq_state_type state_ff, state_in;
   logic        ph_ff, ph_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [1:0]  comp_ff, comp_in;
   logic signed [65:0] acc_ff, acc_in, prod_ff, prod_in, sum_c;
   logic [63:0] rt_s_ff, rt_s_in, rt_res_ff, rt_res_in, rt_bit_ff, rt_bit_in;
   logic [31:0] root_ff, root_in;
   logic [31:0] dv_rem_ff, dv_rem_in;
   logic [47:0] dv_num_ff, dv_num_in, dv_q_ff, dv_q_in;
   logic        dv_neg_ff, dv_neg_in;
   logic signed [16:0] n_ff [3], n_in [3], u_ff [3], u_in [3], v_ff [3], v_in [3];
   logic signed [31:0] t_ff [3], t_in [3];
   logic        degen_ff, degen_in;

   logic [1:0]  i1, i2, isq;
   logic signed [32:0] opa, opb, src;
   logic        neg_term, neg_prod;
   logic [31:0] mag_a, mag_b, src_mag;
   logic [63:0] prod_mag;
   logic [63:0] cand, res_nx, s_nx;
   logic        rt_ge;
   logic [32:0] rem_sh;
   logic        dv_ge;
   logic [31:0] rem_nx;
   logic [47:0] q_nx;
   logic [16:0] q_mag;
   logic [31:0] tv_mag;
   logic [31:0] tv_rnd;

   assign nr[0] = view_normal[15:0];
   assign nr[1] = view_normal[31:16];
   assign nr[2] = view_normal[47:32];
   assign up[0] = up_vector[15:0];
   assign up[1] = up_vector[31:16];
   assign up[2] = up_vector[47:32];

   // shared multiplier operand select
   always_comb begin
      i1       = nx1(comp_ff);
      i2       = nx2(comp_ff);
      isq      = cnt_ff[2:1];
      opa      = '0;
      opb      = '0;
      neg_term = 1'b0;
      if (state_ff == wtv_pkg::ST_SUM) begin
         opa = ph_ff ? 33'(t_ff[isq]) : 33'(nr[isq]);
         opb = opa;
      end else if (!ph_ff) begin
         opa      = cnt_ff[1] ? 33'(up[i2]) : 33'(up[i1]);
         opb      = cnt_ff[1] ? 33'(n_ff[i1]) : 33'(n_ff[i2]);
         neg_term = cnt_ff[1];
      end else begin
         opa      = cnt_ff[1] ? 33'(n_ff[i2]) : 33'(n_ff[i1]);
         opb      = cnt_ff[1] ? 33'(u_ff[i1]) : 33'(u_ff[i2]);
         neg_term = cnt_ff[1];
      end
      mag_a    = opa[32] ? 32'(-opa) : opa[31:0];
      mag_b    = opb[32] ? 32'(-opb) : opb[31:0];
      prod_mag = mag_a * mag_b;
      neg_prod = opa[32] ^ opb[32] ^ neg_term;
      prod_in  = neg_prod ? -$signed({2'b00, prod_mag}) : $signed({2'b00, prod_mag});
      sum_c    = acc_ff + prod_ff;
   end

   // one root digit and one quotient bit per cycle
   always_comb begin
      cand   = rt_res_ff + rt_bit_ff;
      rt_ge  = rt_s_ff >= cand;
      res_nx = rt_ge ? (rt_res_ff >> 1) + rt_bit_ff : rt_res_ff >> 1;
      s_nx   = rt_ge ? rt_s_ff - cand : rt_s_ff;
      rem_sh = {dv_rem_ff, dv_num_ff[47]};
      dv_ge  = rem_sh >= {1'b0, root_ff};
      rem_nx = dv_ge ? 32'(rem_sh - {1'b0, root_ff}) : rem_sh[31:0];
      q_nx   = {dv_q_ff[46:0], dv_ge};
      q_mag  = q_nx[16:0];
      src     = ph_ff ? 33'(t_ff[comp_ff]) : 33'(nr[comp_ff]);
      src_mag = src[32] ? 32'(-src) : src[31:0];
      tv_mag  = sum_c[65] ? 32'(-sum_c) : sum_c[31:0];
      tv_rnd  = (tv_mag + 32'd8192) >> 14;
   end

   always_comb begin
      state_in  = state_ff;
      ph_in     = ph_ff;
      cnt_in    = cnt_ff + 6'd1;
      comp_in   = comp_ff;
      acc_in    = acc_ff;
      rt_s_in   = s_nx;
      rt_res_in = res_nx;
      rt_bit_in = rt_bit_ff >> 2;
      root_in   = root_ff;
      dv_rem_in = rem_nx;
      dv_num_in = dv_num_ff << 1;
      dv_q_in   = q_nx;
      dv_neg_in = dv_neg_ff;
      degen_in  = degen_ff;
      n_in      = n_ff;
      u_in      = u_ff;
      v_in      = v_ff;
      t_in      = t_ff;
      unique case (state_ff)
         wtv_pkg::ST_START: begin
            degen_in = 1'b0;
            ph_in    = 1'b0;
            cnt_in   = '0;
            comp_in  = '0;
            state_in = wtv_pkg::ST_SUM;
         end
         wtv_pkg::ST_SUM: begin
            if (cnt_ff == 6'd0) acc_in = '0;
            else if (cnt_ff[0]) acc_in = sum_c;
            if (cnt_ff == 6'd5) begin
               cnt_in    = '0;
               comp_in   = '0;
               rt_res_in = '0;
               rt_bit_in = 64'd1 << 62;
               if (sum_c == '0) begin
                  degen_in = 1'b1;
                  state_in = wtv_pkg::ST_CROSS;
                  if (ph_ff) u_in = '{default: '0};
                  else n_in = '{default: '0};
               end else begin
                  state_in = wtv_pkg::ST_ROOT;
                  rt_s_in  = ph_ff ? sum_c[63:0] : sum_c[63:0] << 28;
               end
            end
         end
         wtv_pkg::ST_ROOT: begin
            if (cnt_ff == 6'd31) begin
               root_in  = res_nx[31:0];
               comp_in  = '0;
               state_in = wtv_pkg::ST_LOAD;
            end
         end
         wtv_pkg::ST_LOAD: begin
            dv_num_in = (ph_ff ? ({16'b0, src_mag} << 14) : ({16'b0, src_mag} << 28))
                        + {17'b0, root_ff[31:1]};
            dv_rem_in = '0;
            dv_q_in   = '0;
            dv_neg_in = src[32];
            cnt_in    = '0;
            state_in  = wtv_pkg::ST_DIV;
         end
         wtv_pkg::ST_DIV: begin
            if (cnt_ff == 6'd47) begin
               if (ph_ff) u_in[comp_ff] = dv_neg_ff ? -$signed(q_mag) : $signed(q_mag);
               else n_in[comp_ff] = dv_neg_ff ? -$signed(q_mag) : $signed(q_mag);
               cnt_in = '0;
               if (comp_ff == 2'd2) begin
                  comp_in  = '0;
                  state_in = wtv_pkg::ST_CROSS;
               end else begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = wtv_pkg::ST_LOAD;
               end
            end
         end
         wtv_pkg::ST_CROSS: begin
            if (cnt_ff == 6'd0) acc_in = '0;
            else if (cnt_ff[0]) acc_in = sum_c;
            if (cnt_ff == 6'd3) begin
               if (ph_ff) v_in[comp_ff] = sum_c[65] ? -$signed(tv_rnd[16:0])
                                                   : $signed(tv_rnd[16:0]);
               else t_in[comp_ff] = sum_c[31:0];
               cnt_in = '0;
               if (comp_ff == 2'd2) begin
                  comp_in  = '0;
                  ph_in    = 1'b1;
                  state_in = ph_ff ? wtv_pkg::ST_IDLE : wtv_pkg::ST_SUM;
               end else begin
                  comp_in = comp_ff + 2'd1;
               end
            end
         end
         wtv_pkg::ST_IDLE: begin
            cnt_in = '0;
         end
         default: state_in = wtv_pkg::ST_START;
      endcase
      if (kick) state_in = wtv_pkg::ST_START;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wtv_pkg::ST_START;
         ph_ff    <= 1'b0;
         cnt_ff   <= '0;
         comp_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ph_ff    <= ph_in;
         cnt_ff   <= cnt_in;
         comp_ff  <= comp_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      prod_ff   <= prod_in;
      rt_s_ff   <= rt_s_in;
      rt_res_ff <= rt_res_in;
      rt_bit_ff <= rt_bit_in;
      root_ff   <= root_in;
      dv_rem_ff <= dv_rem_in;
      dv_num_ff <= dv_num_in;
      dv_q_ff   <= dv_q_in;
      dv_neg_ff <= dv_neg_in;
      degen_ff  <= degen_in;
      n_ff      <= n_in;
      u_ff      <= u_in;
      v_ff      <= v_in;
      t_ff      <= t_in;
   end

   assign basis.u          = '{x: u_ff[0], y: u_ff[1], z: u_ff[2]};
   assign basis.v          = '{x: v_ff[0], y: v_ff[1], z: v_ff[2]};
   assign basis.n          = '{x: n_ff[0], y: n_ff[1], z: n_ff[2]};
   assign basis.degenerate = degen_ff;
   assign basis.busy       = (state_ff != wtv_pkg::ST_IDLE);

endmodule

// ----- rtl/wtv_pipe.sv -----
// Four-stage point pipeline: offset, products, row sums, round and saturate.
module wtv_pipe (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [wtv_pkg::PT_W-1:0]    req_point_x,
   input  logic signed [wtv_pkg::PT_W-1:0]    req_point_y,
   input  logic signed [wtv_pkg::PT_W-1:0]    req_point_z,
   input  logic signed [wtv_pkg::PT_W-1:0]    eye_x,
   input  logic signed [wtv_pkg::PT_W-1:0]    eye_y,
   input  logic signed [wtv_pkg::PT_W-1:0]    eye_z,
   input  wtv_pkg::basis_type                 basis,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [wtv_pkg::PT_W-1:0]    rsp_view_x,
   output logic signed [wtv_pkg::PT_W-1:0]    rsp_view_y,
   output logic signed [wtv_pkg::PT_W-1:0]    rsp_view_z,
   output logic                               rsp_degenerate
);

   function automatic logic [wtv_pkg::PT_W-1:0] round_sat(
      input logic signed [wtv_pkg::ROW_W-1:0] s);
      logic [wtv_pkg::ROW_W-1:0] m;
      logic [wtv_pkg::ROW_W-1:0] q;
      m = s[wtv_pkg::ROW_W-1] ? wtv_pkg::ROW_W'(-s) : s;
      q = (m + wtv_pkg::ROW_W'(8192)) >> 14;
      if (!s[wtv_pkg::ROW_W-1])
         round_sat = (q > wtv_pkg::ROW_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
      else
         round_sat = (q > wtv_pkg::ROW_W'(32'h8000_0000)) ? 32'h8000_0000
                                                          : 32'(-q[31:0]);
   endfunction

   logic vld1_ff, vld2_ff, vld3_ff, vld4_ff;
   logic adv1, adv2, adv3, adv4;
   logic signed [wtv_pkg::DIFF_W-1:0] d_ff [3];
   logic signed [wtv_pkg::PROD_W-1:0] p_ff [3][3];
   logic signed [wtv_pkg::ROW_W-1:0]  row_ff [3];
   logic signed [wtv_pkg::COEF_W-1:0] coef [3][3];
   logic [wtv_pkg::PT_W-1:0] out_ff [3];
   logic degen_ff;

   assign coef[0] = '{basis.u.x, basis.u.y, basis.u.z};
   assign coef[1] = '{basis.v.x, basis.v.y, basis.v.z};
   assign coef[2] = '{basis.n.x, basis.n.y, basis.n.z};

   // a stage moves when it is empty or the next one moves
   assign adv4      = !vld4_ff || rsp_ready;
   assign adv3      = !vld3_ff || adv4;
   assign adv2      = !vld2_ff || adv3;
   assign adv1      = !vld1_ff || adv2;
   assign req_ready = adv1 && !basis.busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else begin
         if (adv1) vld1_ff <= req_valid && req_ready;
         if (adv2) vld2_ff <= vld1_ff;
         if (adv3) vld3_ff <= vld2_ff;
         if (adv4) vld4_ff <= vld3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         d_ff[0] <= wtv_pkg::DIFF_W'(req_point_x) - wtv_pkg::DIFF_W'(eye_x);
         d_ff[1] <= wtv_pkg::DIFF_W'(req_point_y) - wtv_pkg::DIFF_W'(eye_y);
         d_ff[2] <= wtv_pkg::DIFF_W'(req_point_z) - wtv_pkg::DIFF_W'(eye_z);
      end
      if (adv2) begin
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
               p_ff[r][c] <= coef[r][c] * d_ff[c];
      end
      if (adv3) begin
         for (int r = 0; r < 3; r++)
            row_ff[r] <= wtv_pkg::ROW_W'(p_ff[r][0]) + wtv_pkg::ROW_W'(p_ff[r][1])
                         + wtv_pkg::ROW_W'(p_ff[r][2]);
      end
      if (adv4) begin
         for (int r = 0; r < 3; r++) out_ff[r] <= round_sat(row_ff[r]);
         degen_ff <= basis.degenerate;
      end
   end

   assign rsp_valid      = vld4_ff;
   assign rsp_view_x     = out_ff[0];
   assign rsp_view_y     = out_ff[1];
   assign rsp_view_z     = out_ff[2];
   assign rsp_degenerate = degen_ff;

endmodule

// ----- rtl/wtv_checker.sv -----
// Port-level checks for the world-to-view transform, bound to the top level.
module wtv_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [wtv_pkg::PT_W-1:0]         rsp_view_x,
   input logic [wtv_pkg::PT_W-1:0]         rsp_view_y,
   input logic [wtv_pkg::PT_W-1:0]         rsp_view_z,
   input logic                             rsp_degenerate
);

   // a held word keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_view_x)
         && $stable(rsp_view_y) && $stable(rsp_view_z) && $stable(rsp_degenerate))
      else $error("rsp word changed while stalled");

   a_rst_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("rsp_valid set right after reset");

   // basis is rebuilt after reset, so no point is taken at once
   a_rst_busy: assert property (@(posedge clock) $past(reset) |-> !req_ready)
      else $error("req_ready set right after reset");

   // a degenerate basis has zero u and v rows
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_view_x == '0 && rsp_view_y == '0)
      else $error("degenerate word with nonzero view_x or view_y");

endmodule

bind world_to_view_transform_top wtv_checker u_wtv_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_view_x     (rsp_view_x),
   .rsp_view_y     (rsp_view_y),
   .rsp_view_z     (rsp_view_z),
   .rsp_degenerate (rsp_degenerate)
);
